### hw/rtl/vfvad_pkg.sv
package vfvad_pkg;

    typedef enum logic [1:0] {
        OP_BYTE = 2'd0,
        OP_PIN  = 2'd1,
        OP_TICK = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        EV_VAD_START = 3'd0,
        EV_VAD_END   = 3'd1,
        EV_WAKEUP    = 3'd2,
        EV_INSTR     = 3'd3,
        EV_WAKE_END  = 3'd4
    } t_event;

    typedef enum logic [1:0] {
        REG_VAD_MAX       = 2'd0,
        REG_VAD_SMOOTH    = 2'd1,
        REG_VAD_AGAIN     = 2'd2,
        REG_FRAME_TIMEOUT = 2'd3
    } t_reg;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_SYNC  = 3'd1;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_DATA0 = 3'd4;
    localparam logic [2:0] PH_END   = 3'd7;

    localparam logic [7:0] BYTE_SYNC0   = 8'hA5;
    localparam logic [7:0] BYTE_SYNC1   = 8'hFA;
    localparam logic [7:0] BYTE_END     = 8'hFB;
    localparam logic [7:0] CMD_WAKE     = 8'h81;
    localparam logic [7:0] CMD_WAKE_END = 8'h82;
    localparam logic [7:0] DATA_WAKE1   = 8'h01;
    localparam logic [7:0] DATA_WAKE2   = 8'h02;
    localparam logic [7:0] DATA_ZERO    = 8'h00;

    localparam logic [15:0] RST_VAD_MAX       = 16'd5000;
    localparam logic [15:0] RST_VAD_SMOOTH    = 16'd500;
    localparam logic [15:0] RST_VAD_AGAIN     = 16'd640;
    localparam logic [15:0] RST_FRAME_TIMEOUT = 16'd500;

    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        pin_now;
        logic        in_voice;
        logic        wake_pending;
        logic        st_on;
        logic [15:0] st_left;
        logic        en_on;
        logic [15:0] en_left;
        logic        ag_on;
        logic [15:0] ag_left;
    } t_vad;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] code;
        logic       last;
    } t_result;

endpackage

### hw/rtl/voice_frame_and_vad_event_tracker_unit.sv
// Voice frame and voice-activity event tracker. Each input word is a serial
// byte, a voice-pin change or a 1 ms tick; bytes are parsed into A5 FA
// frames (wakeup, instruction, wakeup end), pin changes and ticks drive the
// voice start, smoothing and again timers. One input word is taken per
// cycle, its full effect settles in that cycle, and its 0 to 2 result words
// enter a 4-entry result queue that drains one word per cycle of i_ready;
// input ready is high while the queue has at least two free entries.
// Timer and timeout registers are at APB byte addresses 0, 4, 8 and 12.
module voice_frame_and_vad_event_tracker_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_pin_level,
    input  logic        i_wakeup_active,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_instruction_code,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int QD = vfvad_pkg::QUEUE_DEPTH;
    localparam int CW = $clog2(QD + 1);

    logic [15:0] r_vad_max;
    logic [15:0] r_vad_smooth;
    logic [15:0] r_vad_again;
    logic [15:0] r_frame_timeout;

    vfvad_pkg::t_vad r_st;
    vfvad_pkg::t_vad n_st;
    logic [2:0]      r_phase;
    logic [2:0]      n_phase;
    logic [7:0]      r_cmd;
    logic [7:0]      n_cmd;
    logic [7:0]      r_d0;
    logic [7:0]      n_d0;
    logic [15:0]     r_fticks;
    logic [15:0]     n_fticks;

    vfvad_pkg::t_result r_q [QD];
    vfvad_pkg::t_result n_q [QD];
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      n_cnt;

    logic               acc;
    logic               pop;
    logic               cfg_wr;
    logic [1:0]         ev_n;
    vfvad_pkg::t_result res0;
    vfvad_pkg::t_result res1;
    logic [2:0]         ev_k0;
    logic [2:0]         ev_k1;
    logic [7:0]         ev_c0;
    logic [7:0]         ev_c1;

    function automatic vfvad_pkg::t_vad pin_logic(vfvad_pkg::t_vad s,
                                                  logic [15:0] mx,
                                                  logic [15:0] sm);
        vfvad_pkg::t_vad r;
        r = s;
        if (r.wake_pending) begin
            r.in_voice     = 1'b0;
            r.wake_pending = 1'b0;
        end
        r.ag_on = 1'b0;
        r.en_on = 1'b0;
        if (!r.in_voice) begin
            r.st_on = 1'b0;
        end
        if (!r.pin_now && !r.in_voice) begin
            r.in_voice = 1'b1;
            r.st_on    = 1'b1;
            r.st_left  = mx;
        end else if (r.pin_now) begin
            r.en_on   = 1'b1;
            r.en_left = sm;
        end
        return r;
    endfunction

    assign o_ready = (r_cnt <= CW'(QD - 2));
    assign acc     = i_valid && o_ready;
    assign o_valid = (r_cnt != '0);
    assign pop     = o_valid && i_ready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    assign o_event_res        = r_q[0].event_res;
    assign o_instruction_code = r_q[0].code;
    assign o_last             = r_q[0].last;

    always_comb begin
        case (vfvad_pkg::t_reg'(paddr[3:2]))
            vfvad_pkg::REG_VAD_MAX:       prdata = {16'd0, r_vad_max};
            vfvad_pkg::REG_VAD_SMOOTH:    prdata = {16'd0, r_vad_smooth};
            vfvad_pkg::REG_VAD_AGAIN:     prdata = {16'd0, r_vad_again};
            vfvad_pkg::REG_FRAME_TIMEOUT: prdata = {16'd0, r_frame_timeout};
            default:                      prdata = 32'd0;
        endcase
    end

    always_comb begin
        logic fs;
        logic fe;
        logic fa;
        logic vs;
        n_st     = r_st;
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_d0     = r_d0;
        n_fticks = r_fticks;
        ev_n     = 2'd0;
        ev_k0    = vfvad_pkg::EV_VAD_START;
        ev_k1    = vfvad_pkg::EV_VAD_START;
        ev_c0    = 8'd0;
        ev_c1    = 8'd0;
        fs       = 1'b0;
        fe       = 1'b0;
        fa       = 1'b0;
        vs       = 1'b0;
        if (acc) begin
            case (vfvad_pkg::t_op'(i_operation))
                vfvad_pkg::OP_BYTE: begin
                    case (r_phase)
                        vfvad_pkg::PH_HUNT: begin
                            if (i_rx_byte == vfvad_pkg::BYTE_SYNC0) begin
                                n_phase = vfvad_pkg::PH_SYNC;
                            end
                        end
                        vfvad_pkg::PH_SYNC: begin
                            if (i_rx_byte == vfvad_pkg::BYTE_SYNC1) begin
                                n_phase  = r_phase + 3'd1;
                                n_fticks = 16'd0;
                            end else begin
                                n_phase = vfvad_pkg::PH_HUNT;
                            end
                        end
                        vfvad_pkg::PH_CMD: begin
                            n_cmd   = i_rx_byte;
                            n_phase = vfvad_pkg::PH_DATA0;
                        end
                        vfvad_pkg::PH_DATA0: begin
                            n_d0    = i_rx_byte;
                            n_phase = r_phase + 3'd1;
                        end
                        vfvad_pkg::PH_END: begin
                            n_phase = vfvad_pkg::PH_HUNT;
                            if (i_rx_byte == vfvad_pkg::BYTE_END) begin
                                if (r_cmd == vfvad_pkg::CMD_WAKE) begin
                                    ev_n = 2'd1;
                                    if (r_d0 == vfvad_pkg::DATA_WAKE1 ||
                                        r_d0 == vfvad_pkg::DATA_WAKE2) begin
                                        ev_k0             = vfvad_pkg::EV_WAKEUP;
                                        n_st.wake_pending = 1'b1;
                                    end else begin
                                        ev_k0 = vfvad_pkg::EV_INSTR;
                                        ev_c0 = r_d0;
                                    end
                                end else if (r_cmd == vfvad_pkg::CMD_WAKE_END &&
                                             r_d0 == vfvad_pkg::DATA_ZERO) begin
                                    ev_n  = 2'd1;
                                    ev_k0 = vfvad_pkg::EV_WAKE_END;
                                end
                            end
                        end
                        default: begin
                            n_phase = r_phase + 3'd1;
                        end
                    endcase
                end
                vfvad_pkg::OP_PIN: begin
                    n_st.pin_now = i_pin_level;
                    vs = r_st.in_voice && !r_st.wake_pending;
                    if (!i_pin_level && !vs) begin
                        ev_n  = 2'd1;
                        ev_k0 = vfvad_pkg::EV_VAD_START;
                    end
                    n_st = pin_logic(n_st, r_vad_max, r_vad_smooth);
                end
                vfvad_pkg::OP_TICK: begin
                    fs = r_st.st_on && (r_st.st_left <= 16'd1);
                    fe = r_st.en_on && (r_st.en_left <= 16'd1);
                    fa = r_st.ag_on && (r_st.ag_left <= 16'd1);
                    if (r_st.st_on) begin
                        n_st.st_left = fs ? 16'd0 : r_st.st_left - 16'd1;
                    end
                    if (r_st.en_on) begin
                        n_st.en_left = fe ? 16'd0 : r_st.en_left - 16'd1;
                    end
                    if (r_st.ag_on) begin
                        n_st.ag_left = fa ? 16'd0 : r_st.ag_left - 16'd1;
                    end
                    if (r_phase > vfvad_pkg::PH_SYNC) begin
                        if (r_fticks != 16'hFFFF) begin
                            n_fticks = r_fticks + 16'd1;
                        end
                        if (n_fticks >= r_frame_timeout) begin
                            n_phase = vfvad_pkg::PH_HUNT;
                        end
                    end
                    if (fs && n_st.st_on) begin
                        n_st.st_on    = 1'b0;
                        n_st.in_voice = 1'b0;
                        ev_k0         = vfvad_pkg::EV_VAD_END;
                        ev_n          = 2'd1;
                        if (i_wakeup_active) begin
                            n_st.ag_on   = 1'b1;
                            n_st.ag_left = r_vad_again;
                        end
                    end
                    if (fe && n_st.en_on) begin
                        n_st.en_on    = 1'b0;
                        n_st.in_voice = 1'b0;
                        n_st.st_on    = 1'b0;
                        if (ev_n == 2'd0) begin
                            ev_k0 = vfvad_pkg::EV_VAD_END;
                        end else begin
                            ev_k1 = vfvad_pkg::EV_VAD_END;
                        end
                        ev_n = ev_n + 2'd1;
                    end
                    if (fa && n_st.ag_on) begin
                        n_st.ag_on        = 1'b0;
                        n_st.wake_pending = 1'b1;
                        if (!n_st.pin_now) begin
                            if (ev_n == 2'd0) begin
                                ev_k0 = vfvad_pkg::EV_VAD_START;
                                ev_n  = 2'd1;
                            end else if (ev_n == 2'd1) begin
                                ev_k1 = vfvad_pkg::EV_VAD_START;
                                ev_n  = 2'd2;
                            end
                        end
                        n_st = pin_logic(n_st, r_vad_max, r_vad_smooth);
                    end
                end
                default: begin
                    n_st = r_st;
                end
            endcase
        end
    end

    always_comb begin
        res0.event_res = vfvad_pkg::t_event'(ev_k0);
        res0.code      = ev_c0;
        res0.last      = (ev_n == 2'd1);
        res1.event_res = vfvad_pkg::t_event'(ev_k1);
        res1.code      = ev_c1;
        res1.last      = 1'b1;
    end

    always_comb begin
        logic [CW-1:0] base;
        n_q  = r_q;
        base = r_cnt;
        if (pop) begin
            for (int i = 0; i < QD - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
            base = r_cnt - CW'(1);
        end
        for (int i = 0; i < QD; i++) begin
            if (acc && ev_n != 2'd0 && CW'(i) == base) begin
                n_q[i] = res0;
            end
            if (acc && ev_n == 2'd2 && CW'(i) == base + CW'(1)) begin
                n_q[i] = res1;
            end
        end
        n_cnt = base + (acc ? CW'(ev_n) : CW'(0));
    end

    always_ff @(posedge i_clk) begin
        n_q_copy : for (int i = 0; i < QD; i++) begin
            r_q[i] <= n_q[i];
        end
        r_cmd <= n_cmd;
        r_d0  <= n_d0;
        if (!i_rst_n) begin
            r_cnt           <= '0;
            r_st            <= vfvad_pkg::t_vad'{pin_now: 1'b1, default: '0};
            r_phase         <= vfvad_pkg::PH_HUNT;
            r_fticks        <= 16'd0;
            r_vad_max       <= vfvad_pkg::RST_VAD_MAX;
            r_vad_smooth    <= vfvad_pkg::RST_VAD_SMOOTH;
            r_vad_again     <= vfvad_pkg::RST_VAD_AGAIN;
            r_frame_timeout <= vfvad_pkg::RST_FRAME_TIMEOUT;
        end else begin
            r_cnt    <= n_cnt;
            r_st     <= n_st;
            r_phase  <= n_phase;
            r_fticks <= n_fticks;
            if (cfg_wr) begin
                case (vfvad_pkg::t_reg'(paddr[3:2]))
                    vfvad_pkg::REG_VAD_MAX:       r_vad_max       <= pwdata[15:0];
                    vfvad_pkg::REG_VAD_SMOOTH:    r_vad_smooth    <= pwdata[15:0];
                    vfvad_pkg::REG_VAD_AGAIN:     r_vad_again     <= pwdata[15:0];
                    vfvad_pkg::REG_FRAME_TIMEOUT: r_frame_timeout <= pwdata[15:0];
                    default:                      r_vad_max       <= r_vad_max;
                endcase
            end
        end
    end

endmodule

### dv/voice_frame_and_vad_event_tracker_unit_test.sv
module voice_frame_and_vad_event_tracker_unit_test;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 8;

    class vad_frame_tracker;
        logic [15:0] max_ms, smooth_ms, again_ms, frame_limit_ms;
        logic        pin_now, in_voice, wake_pending;
        logic        st_on, en_on, ag_on;
        logic [15:0] st_left, en_left, ag_left;
        logic [2:0]  phase;
        logic [7:0]  cmd, data0;
        logic [15:0] frame_ticks;
        vfvad_pkg::t_result step_events[$];
        vfvad_pkg::t_result pending_events[$];
        int          n_bad;

        function new();
            max_ms         = vfvad_pkg::RST_VAD_MAX;
            smooth_ms      = vfvad_pkg::RST_VAD_SMOOTH;
            again_ms       = vfvad_pkg::RST_VAD_AGAIN;
            frame_limit_ms = vfvad_pkg::RST_FRAME_TIMEOUT;
            pin_now        = 1'b1;
            in_voice       = 1'b0;
            wake_pending   = 1'b0;
            st_on          = 1'b0;
            en_on          = 1'b0;
            ag_on          = 1'b0;
            st_left        = '0;
            en_left        = '0;
            ag_left        = '0;
            phase          = vfvad_pkg::PH_HUNT;
            cmd            = '0;
            data0          = '0;
            frame_ticks    = '0;
            n_bad          = 0;
        endfunction

        function void set_reg(vfvad_pkg::t_reg r, logic [15:0] v);
            case (r)
                vfvad_pkg::REG_VAD_MAX:       max_ms = v;
                vfvad_pkg::REG_VAD_SMOOTH:    smooth_ms = v;
                vfvad_pkg::REG_VAD_AGAIN:     again_ms = v;
                vfvad_pkg::REG_FRAME_TIMEOUT: frame_limit_ms = v;
                default: ;
            endcase
        endfunction

        function void raise(vfvad_pkg::t_event k, logic [7:0] c);
            vfvad_pkg::t_result r;
            r.event_res = k;
            r.code      = c;
            r.last      = 1'b0;
            step_events.push_back(r);
        endfunction

        function void run_pin();
            if (wake_pending) begin
                in_voice     = 1'b0;
                wake_pending = 1'b0;
            end
            ag_on = 1'b0;
            en_on = 1'b0;
            if (!in_voice)
                st_on = 1'b0;
            if (pin_now == 1'b0 && !in_voice) begin
                in_voice = 1'b1;
                raise(vfvad_pkg::EV_VAD_START, 8'h00);
                st_on   = 1'b1;
                st_left = max_ms;
            end else if (pin_now == 1'b1) begin
                en_on   = 1'b1;
                en_left = smooth_ms;
            end
        endfunction

        function void run_tick(logic wake);
            logic fire_st, fire_en, fire_ag;
            fire_st = st_on && st_left <= 16'd1;
            fire_en = en_on && en_left <= 16'd1;
            fire_ag = ag_on && ag_left <= 16'd1;
            if (st_on) st_left = fire_st ? 16'd0 : st_left - 16'd1;
            if (en_on) en_left = fire_en ? 16'd0 : en_left - 16'd1;
            if (ag_on) ag_left = fire_ag ? 16'd0 : ag_left - 16'd1;
            if (phase > vfvad_pkg::PH_SYNC) begin
                if (frame_ticks != 16'hFFFF)
                    frame_ticks = frame_ticks + 16'd1;
                if (frame_ticks >= frame_limit_ms)
                    phase = vfvad_pkg::PH_HUNT;
            end
            if (fire_st && st_on) begin
                st_on    = 1'b0;
                in_voice = 1'b0;
                raise(vfvad_pkg::EV_VAD_END, 8'h00);
                if (wake) begin
                    ag_on   = 1'b1;
                    ag_left = again_ms;
                end
            end
            if (fire_en && en_on) begin
                en_on    = 1'b0;
                in_voice = 1'b0;
                st_on    = 1'b0;
                raise(vfvad_pkg::EV_VAD_END, 8'h00);
            end
            if (fire_ag && ag_on) begin
                ag_on        = 1'b0;
                wake_pending = 1'b1;
                run_pin();
            end
        endfunction

        function void take_byte(logic [7:0] b);
            case (phase)
                vfvad_pkg::PH_HUNT: begin
                    if (b == vfvad_pkg::BYTE_SYNC0)
                        phase = vfvad_pkg::PH_SYNC;
                end
                vfvad_pkg::PH_SYNC: begin
                    if (b == vfvad_pkg::BYTE_SYNC1) begin
                        phase       = vfvad_pkg::PH_SYNC + 3'd1;
                        frame_ticks = '0;
                    end else begin
                        phase = vfvad_pkg::PH_HUNT;
                    end
                end
                vfvad_pkg::PH_CMD: begin
                    cmd   = b;
                    phase = vfvad_pkg::PH_DATA0;
                end
                vfvad_pkg::PH_DATA0: begin
                    data0 = b;
                    phase = vfvad_pkg::PH_DATA0 + 3'd1;
                end
                vfvad_pkg::PH_END: begin
                    phase = vfvad_pkg::PH_HUNT;
                    if (b == vfvad_pkg::BYTE_END) begin
                        if (cmd == vfvad_pkg::CMD_WAKE) begin
                            if (data0 == vfvad_pkg::DATA_WAKE1 ||
                                data0 == vfvad_pkg::DATA_WAKE2) begin
                                raise(vfvad_pkg::EV_WAKEUP, 8'h00);
                                wake_pending = 1'b1;
                            end else begin
                                raise(vfvad_pkg::EV_INSTR, data0);
                            end
                        end else if (cmd == vfvad_pkg::CMD_WAKE_END &&
                                     data0 == vfvad_pkg::DATA_ZERO) begin
                            raise(vfvad_pkg::EV_WAKE_END, 8'h00);
                        end
                    end
                end
                default: phase = phase + 3'd1;
            endcase
        endfunction

        function void note_word(logic [1:0] op, logic [7:0] rx, logic pin, logic wake);
            vfvad_pkg::t_result r;
            step_events.delete();
            case (op)
                vfvad_pkg::OP_BYTE: take_byte(rx);
                vfvad_pkg::OP_PIN: begin
                    pin_now = pin;
                    run_pin();
                end
                vfvad_pkg::OP_TICK: run_tick(wake);
                default: ;
            endcase
            while (step_events.size() > 2)
                void'(step_events.pop_back());
            if (step_events.size() > 0) begin
                r = step_events.pop_back();
                r.last = 1'b1;
                step_events.push_back(r);
            end
            foreach (step_events[k])
                pending_events.push_back(step_events[k]);
        endfunction

        function void check_event(logic [2:0] ev, logic [7:0] code, logic last);
            vfvad_pkg::t_result want;
            if (pending_events.size() == 0) begin
                $error("unexpected event word: event_res %0d instruction_code %0d last %0d",
                       ev, code, last);
                n_bad++;
                return;
            end
            want = pending_events.pop_front();
            if (ev !== want.event_res) begin
                $error("event_res expected %0d actual %0d", want.event_res, ev);
                n_bad++;
            end
            if (code !== want.code) begin
                $error("instruction_code expected %0d actual %0d", want.code, code);
                n_bad++;
            end
            if (last !== want.last) begin
                $error("last expected %0d actual %0d", want.last, last);
                n_bad++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_operation;
    logic [7:0]  i_rx_byte;
    logic        i_pin_level;
    logic        i_wakeup_active;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_event_res;
    logic [7:0]  o_instruction_code;
    logic        o_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vad_frame_tracker sb;
    int burst_left = 0;
    int ready_mode = 0;
    int ready_left = 0;
    int ready_phase = 0;
    int cycles = 0;

    voice_frame_and_vad_event_tracker_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_operation        (i_operation),
        .i_rx_byte          (i_rx_byte),
        .i_pin_level        (i_pin_level),
        .i_wakeup_active    (i_wakeup_active),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_event_res        (o_event_res),
        .o_instruction_code (o_instruction_code),
        .o_last             (o_last),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("voice_frame_and_vad_event_tracker_unit_test NOT OK");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check_event(o_event_res, o_instruction_code, o_last);
    end

    always @(negedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 300);
        end
        ready_left--;
        ready_phase++;
        case (ready_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= 1'($urandom_range(0, 1));
            2: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= (ready_phase % 8) < 5;
        endcase
    end

    task automatic send_word(logic [1:0] op, logic [7:0] rx, logic pin);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        i_valid         <= 1'b1;
        i_operation     <= op;
        i_rx_byte       <= rx;
        i_pin_level     <= pin;
        i_wakeup_active <= 1'($urandom_range(0, 1));
        do @(posedge i_clk); while (!o_ready);
        sb.note_word(op, rx, pin, i_wakeup_active);
        @(negedge i_clk);
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_word(vfvad_pkg::OP_TICK, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_frame(logic [7:0] c, logic [7:0] d0, logic [7:0] e, bit jitter);
        logic [7:0] bytes[8];
        bytes = '{vfvad_pkg::BYTE_SYNC0, vfvad_pkg::BYTE_SYNC1, 8'($urandom), c, d0,
                  8'($urandom), 8'($urandom), e};
        foreach (bytes[k]) begin
            send_word(vfvad_pkg::OP_BYTE, bytes[k], 1'($urandom));
            if (jitter && $urandom_range(0, 99) < 12)
                send_ticks($urandom_range(1, 3));
        end
    endtask

    // hold the sender until every expected word is out and the block is quiet
    task automatic drain_and_hold();
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apb_write(vfvad_pkg::t_reg r, logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= {16'h0000, v};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(r, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_timers(logic [15:0] mx, logic [15:0] sm, logic [15:0] ag,
                              logic [15:0] to);
        apb_write(vfvad_pkg::REG_VAD_MAX, mx);
        apb_write(vfvad_pkg::REG_VAD_SMOOTH, sm);
        apb_write(vfvad_pkg::REG_VAD_AGAIN, ag);
        apb_write(vfvad_pkg::REG_FRAME_TIMEOUT, to);
    endtask

    task automatic run_random(int n_words);
        int sent;
        int pick;
        logic [7:0] c, d0, e;
        sent = 0;
        while (sent < n_words) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                case ($urandom_range(0, 3))
                    0, 1: c = vfvad_pkg::CMD_WAKE;
                    2: c = vfvad_pkg::CMD_WAKE_END;
                    default: c = 8'($urandom);
                endcase
                case ($urandom_range(0, 4))
                    0: d0 = vfvad_pkg::DATA_WAKE1;
                    1: d0 = vfvad_pkg::DATA_WAKE2;
                    2: d0 = vfvad_pkg::DATA_ZERO;
                    default: d0 = 8'($urandom);
                endcase
                e = ($urandom_range(0, 99) < 85) ? vfvad_pkg::BYTE_END : 8'($urandom);
                send_frame(c, d0, e, 1'b1);
                sent += 8;
            end else if (pick < 40) begin
                send_word(vfvad_pkg::OP_BYTE, vfvad_pkg::BYTE_SYNC0, 1'($urandom));
                send_word(vfvad_pkg::OP_BYTE,
                          $urandom_range(0, 1) ? vfvad_pkg::BYTE_SYNC0 : 8'($urandom),
                          1'($urandom));
                sent += 2;
            end else if (pick < 58) begin
                send_word(vfvad_pkg::OP_PIN, 8'($urandom),
                          ($urandom_range(0, 9) < 7) ? ~sb.pin_now : 1'($urandom));
                sent++;
            end else if (pick < 90) begin
                pick = $urandom_range(1, 12);
                send_ticks(pick);
                sent += pick;
            end else if (pick < 97) begin
                send_word(vfvad_pkg::OP_BYTE, 8'($urandom), 1'($urandom));
                sent++;
            end else begin
                send_word(OP_UNUSED, 8'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        int ph;
        sb = new();
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_operation     = vfvad_pkg::OP_BYTE;
        i_rx_byte       = 8'h00;
        i_pin_level     = 1'b1;
        i_wakeup_active = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_frame(vfvad_pkg::CMD_WAKE, vfvad_pkg::DATA_WAKE1, vfvad_pkg::BYTE_END, 1'b0);
        send_word(vfvad_pkg::OP_PIN, 8'hFF, 1'b0);
        send_word(vfvad_pkg::OP_PIN, 8'h00, 1'b1);
        send_word(vfvad_pkg::OP_TICK, 8'h00, 1'b0);
        send_frame(vfvad_pkg::CMD_WAKE, 8'hFF, vfvad_pkg::BYTE_END, 1'b0);
        send_word(OP_UNUSED, 8'hFF, 1'b1);
        // sync miss: second A5 is dropped, so the FA does not start a frame
        send_word(vfvad_pkg::OP_BYTE, vfvad_pkg::BYTE_SYNC0, 1'b0);
        send_word(vfvad_pkg::OP_BYTE, vfvad_pkg::BYTE_SYNC0, 1'b0);
        send_word(vfvad_pkg::OP_BYTE, vfvad_pkg::BYTE_SYNC1, 1'b0);
        send_word(vfvad_pkg::OP_BYTE, 8'h00, 1'b0);

        for (ph = 0; ph < 8; ph++) begin
            drain_and_hold();
            case (ph)
                0: set_timers(16'($urandom_range(2, 20)), 16'($urandom_range(2, 20)),
                              16'($urandom_range(2, 20)), 16'($urandom_range(10, 40)));
                1: set_timers(16'd1, 16'd1, 16'd1, 16'd1);
                2: set_timers(16'd0, 16'd0, 16'd0, 16'd0);
                3: set_timers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                default: set_timers(16'($urandom_range(1, 40)), 16'($urandom_range(1, 12)),
                                    16'($urandom_range(1, 12)), 16'($urandom_range(4, 60)));
            endcase
            if (ph == 3) begin
                run_random(60);
            end else if (ph == 4) begin
                run_random(85);
                drain_and_hold();
                run_random(85);
            end else begin
                run_random(170);
            end
        end

        drain_and_hold();
        repeat (16) @(posedge i_clk);
        if (sb.n_bad == 0 && sb.pending_events.size() == 0) begin
            $display("voice_frame_and_vad_event_tracker_unit_test OK");
        end else begin
            $display("voice_frame_and_vad_event_tracker_unit_test NOT OK");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/vfvad_pkg.sv
hw/rtl/voice_frame_and_vad_event_tracker_unit.sv
dv/voice_frame_and_vad_event_tracker_unit_test.sv
